// File: hdl/ccan_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccan_pkg: shared types and constants for the cleartext canonicalizer
// character codes, controller states, and the command/status structs
// ----------------------------------------------------------------------------
package ccan_pkg;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	localparam int NUM_EMIT = 8;

	// line phase, one-hot
	typedef enum logic [3:0] {
		PH_START  = 4'b0001,
		PH_DASH   = 4'b0010,
		PH_DASHSP = 4'b0100,
		PH_MID    = 4'b1000
	} phase_t;

	// controller states, one-hot; emission states follow in emission order
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_PLAN  = 10'b00_0000_0010,
		ST_CR    = 10'b00_0000_0100,
		ST_LF    = 10'b00_0000_1000,
		ST_PDASH = 10'b00_0001_0000,
		ST_WS    = 10'b00_0010_0000,
		ST_WCR   = 10'b00_0100_0000,
		ST_BYTE  = 10'b00_1000_0000,
		ST_EDASH = 10'b01_0000_0000,
		ST_BARE  = 10'b10_0000_0000
	} state_t;

	typedef enum logic [2:0] {
		SEL_CR   = 3'd0,
		SEL_LF   = 3'd1,
		SEL_DASH = 3'd2,
		SEL_WS   = 3'd3,
		SEL_BYTE = 3'd4,
		SEL_BARE = 3'd5
	} out_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     idx_clr;
		logic     idx_inc;
		logic     emit;
		out_sel_t sel;
		logic     final_res;
		logic     commit;
	} cmd_t;

	// need bits in emission order: cr, lf, pre dash, ws run, held cr,
	// byte, end dash, bare marker
	typedef struct packed {
		logic [NUM_EMIT-1:0] need;
		logic                idx_last;
		logic                out_free;
	} status_t;

endpackage

`default_nettype wire

// File: hdl/cleartext_canonicaliser_core.sv
`default_nettype none
// sequencing: an item is taken in the idle state, decoded in the plan state,
//   then each result is registered into the output register
// rate: the controller emits one result per cycle while the output is free, through
//   the single output register; a new item is taken only when it is idle again
// reset: arst_n clears the controller, line state and output valid at once;
//   the held whitespace store is not cleared, entries are used only after written
// ----------------------------------------------------------------------------
// cleartext_canonicaliser_core: streaming cleartext canonicalizer
// turns signed-text bytes into canonical form: line endings become crlf,
// trailing blanks and a cr before lf are dropped, dash escapes are removed
// ----------------------------------------------------------------------------
module cleartext_canonicaliser_core #(
	parameter int MAX_PENDING_WS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
	input  wire logic        s_tlast,   // is_last
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] out_byte, [8] text_done, [15:9] zero
	output logic             m_tlast,   // run_last
	output logic [1:0]       m_tuser    // [0] byte_valid, [1] overflow
);
	import ccan_pkg::*;

	cmd_t    cmd;
	status_t status;

	// controller: takes one transaction, then walks its result list in order
	// (crlf, dash, held blanks, held cr, byte, closing dash, bare end marker)
	ccan_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: decodes the held byte against the line state, keeps the
	// pending blank run in a small store, and drives the output register
	ccan_dp #(
		.MAX_PENDING_WS (MAX_PENDING_WS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// File: hdl/ccan_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccan_ctrl: sequencing controller
// walks the result list of one item; while the output is free, one result per cycle
// ----------------------------------------------------------------------------
module ccan_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire ccan_pkg::status_t status,
	output ccan_pkg::cmd_t         cmd
);
	import ccan_pkg::*;

	state_t              state_q;
	state_t              state_d;
	logic [NUM_EMIT-1:0] cur_pos;
	logic [NUM_EMIT-1:0] later;
	logic [NUM_EMIT-1:0] first_all;
	logic [NUM_EMIT-1:0] first_later;

	assign cur_pos     = state_q[NUM_EMIT+1:2];
	// needed results after the current one
	assign later       = status.need & ~(cur_pos | (cur_pos - NUM_EMIT'(1)));
	assign first_all   = status.need & (~status.need + NUM_EMIT'(1));
	assign first_later = later & (~later + NUM_EMIT'(1));
	assign s_tready    = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.sel = SEL_BARE;
		unique case (state_q) inside
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_PLAN;
				end
			end
			ST_PLAN: begin
				cmd.idx_clr = 1'b1;
				if (status.need == '0) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					state_d = state_t'({first_all, 2'b00});
				end
			end
			ST_CR, ST_LF, ST_PDASH, ST_WS, ST_WCR, ST_BYTE, ST_EDASH, ST_BARE: begin
				unique case (state_q) inside
					ST_CR:             cmd.sel = SEL_CR;
					ST_LF:             cmd.sel = SEL_LF;
					ST_PDASH, ST_EDASH: cmd.sel = SEL_DASH;
					ST_WS:             cmd.sel = SEL_WS;
					ST_WCR:            cmd.sel = SEL_CR;
					ST_BYTE:           cmd.sel = SEL_BYTE;
					default:           cmd.sel = SEL_BARE;
				endcase
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (state_q == ST_WS && !status.idx_last) begin
						cmd.idx_inc = 1'b1;
					end else if (later == '0) begin
						cmd.final_res = 1'b1;
						cmd.commit    = 1'b1;
						state_d       = ST_IDLE;
					end else begin
						state_d = state_t'({first_later, 2'b00});
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: hdl/ccan_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccan_dp: datapath
// line state, held whitespace store, item decode and output register
// ----------------------------------------------------------------------------
module ccan_dp #(
	parameter int MAX_PENDING_WS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        s_tdata,
	input  wire logic              s_tlast,
	input  wire ccan_pkg::cmd_t    cmd,
	output ccan_pkg::status_t      status,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [15:0]            m_tdata,
	output logic                   m_tlast,
	output logic [1:0]             m_tuser
);
	import ccan_pkg::*;

	localparam int CNTW = $clog2(MAX_PENDING_WS + 1);
	localparam int IDXW = (MAX_PENDING_WS > 1) ? $clog2(MAX_PENDING_WS) : 1;

	// item and line state
	logic [7:0]      byte_q;
	logic            last_q;
	phase_t          phase_q;
	logic            first_q;
	logic [CNTW-1:0] cnt_q;
	logic            cr_q;
	logic [IDXW-1:0] idx_q;
	logic [IDXW-1:0] idx_d;

	// held whitespace kinds, 1 = tab
	logic            kind_mem [MAX_PENDING_WS];
	logic            rd_kind_q;

	// output register
	logic            ovalid_q;
	logic [7:0]      obyte_q;
	logic            obv_q;
	logic            olast_q;
	logic            odone_q;
	logic            oovf_q;

	// decode
	logic            is_dash, is_sp, is_tab, is_ws, is_lf, is_cr, is_other;
	logic            ph_start, ph_dash, ph_dsp;
	logic            body, flush, ovf, cnt_full;
	logic            need_crlf, need_pdash, need_ws, need_wcr, need_byte, need_edash;
	phase_t          ph_after;
	logic [CNTW-1:0] cnt_base;
	logic [7:0]      emit_byte;

	assign is_dash  = (byte_q == CH_DASH);
	assign is_sp    = (byte_q == CH_SPACE);
	assign is_tab   = (byte_q == CH_TAB);
	assign is_ws    = is_sp || is_tab;
	assign is_lf    = (byte_q == CH_LF);
	assign is_cr    = (byte_q == CH_CR);
	assign is_other = !(is_ws || is_lf || is_cr);
	assign ph_start = (phase_q == PH_START);
	assign ph_dash  = (phase_q == PH_DASH);
	assign ph_dsp   = (phase_q == PH_DASHSP);
	assign cnt_full = (cnt_q >= CNTW'(MAX_PENDING_WS));

	assign body  = !(ph_start && is_dash) && !(ph_dash && is_sp);
	assign flush = body && ((is_ws && (cr_q || cnt_full)) || (is_cr && cr_q) || is_other);
	assign ovf   = is_ws && !cr_q;

	always_comb begin
		if (!body) begin
			ph_after = ph_start ? PH_DASH : PH_DASHSP;
		end else if (is_lf) begin
			ph_after = PH_START;
		end else if (flush) begin
			ph_after = PH_MID;
		end else begin
			ph_after = ph_dsp ? PH_DASHSP : PH_MID;
		end
	end

	assign need_crlf  = ph_start && !first_q;
	assign need_pdash = ph_dash && !is_sp;
	assign need_ws    = flush && (cnt_q != '0);
	assign need_wcr   = flush && cr_q;
	assign need_byte  = body && is_other;
	assign need_edash = (body && is_lf && ph_dsp)
		|| (last_q && (ph_after == PH_DASH || ph_after == PH_DASHSP));

	always_comb begin
		status.need[0] = need_crlf;
		status.need[1] = need_crlf;
		status.need[2] = need_pdash;
		status.need[3] = need_ws;
		status.need[4] = need_wcr;
		status.need[5] = need_byte;
		status.need[6] = need_edash;
		status.need[7] = last_q && !(need_crlf || need_pdash || need_ws || need_wcr
			|| need_byte || need_edash);
		status.idx_last = ((CNTW'(idx_q) + CNTW'(1)) == cnt_q);
		status.out_free = !ovalid_q || m_tready;
	end

	// flush index; the store is read ahead, registered at the next index
	always_comb begin
		if (cmd.idx_clr) begin
			idx_d = '0;
		end else if (cmd.idx_inc) begin
			idx_d = idx_q + IDXW'(1);
		end else begin
			idx_d = idx_q;
		end
	end

	assign cnt_base = flush ? '0 : cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.commit && body && is_ws) begin
			kind_mem[IDXW'(cnt_base)] <= is_tab;
		end
		rd_kind_q <= kind_mem[idx_d];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			byte_q <= s_tdata;
			last_q <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			first_q <= 1'b1;
			cnt_q   <= '0;
			cr_q    <= 1'b0;
			idx_q   <= '0;
		end else begin
			idx_q <= idx_d;
			if (cmd.commit) begin
				if (last_q) begin
					phase_q <= PH_START;
					first_q <= 1'b1;
					cnt_q   <= '0;
					cr_q    <= 1'b0;
				end else begin
					phase_q <= ph_after;
					first_q <= 1'b0;
					if (!body) begin
						cnt_q <= cnt_q;
						cr_q  <= cr_q;
					end else if (is_ws) begin
						cnt_q <= cnt_base + CNTW'(1);
						cr_q  <= 1'b0;
					end else if (is_cr) begin
						cnt_q <= cnt_base;
						cr_q  <= 1'b1;
					end else begin
						cnt_q <= '0;
						cr_q  <= 1'b0;
					end
				end
			end
		end
	end

	always_comb begin
		case (cmd.sel)
			SEL_CR:   emit_byte = CH_CR;
			SEL_LF:   emit_byte = CH_LF;
			SEL_DASH: emit_byte = CH_DASH;
			SEL_WS:   emit_byte = rd_kind_q ? CH_TAB : CH_SPACE;
			SEL_BYTE: emit_byte = byte_q;
			default:  emit_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			obyte_q <= emit_byte;
			obv_q   <= (cmd.sel != SEL_BARE);
			olast_q <= cmd.final_res;
			odone_q <= cmd.final_res && last_q;
			oovf_q  <= (cmd.sel == SEL_WS) && ovf;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {7'd0, odone_q, obyte_q};
	assign m_tlast  = olast_q;
	assign m_tuser  = {oovf_q, obv_q};

endmodule

`default_nettype wire

// File: hdl/ccan_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccan_checker: port-level checks for the canonicalizer
// watches the output stream and the bind attaches it to the top level
// ----------------------------------------------------------------------------
module ccan_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic [1:0]  m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output changed while stalled");

	// end of text closes the run of its item
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> m_tlast)
		else $error("text done without run last");

	// a bare marker is zero and only ends a text
	a_bare: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'h00 && m_tdata[8] && !m_tuser[1])
		else $error("bad bare end marker");

	// overflowed bytes are blanks
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0]
			&& (m_tdata[7:0] == 8'h20 || m_tdata[7:0] == 8'h09))
		else $error("overflow flag on non-blank byte");

endmodule

bind cleartext_canonicaliser_core ccan_checker u_ccan_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

`default_nettype wire
